FILE: sv/i2cms_pkg.sv
// Shared types, codes and sizes for the I2C master transfer sequencer.
package i2cms_pkg;

   // Buffer sizing
   localparam int BUF_DEPTH = 32;
   localparam int BUF_AW    = $clog2(BUF_DEPTH);
   localparam int CNT_W     = BUF_AW + 1;

   // Request and bus event codes
   localparam logic [3:0] REQ_START_WRITE = 4'd0;
   localparam logic [3:0] REQ_START_READ  = 4'd1;
   localparam logic [3:0] REQ_START_SENT  = 4'd2;
   localparam logic [3:0] REQ_ADDR_SENT   = 4'd3;
   localparam logic [3:0] REQ_TX_EMPTY    = 4'd4;
   localparam logic [3:0] REQ_BYTE_RCVD   = 4'd5;
   localparam logic [3:0] REQ_ERROR       = 4'd6;
   localparam logic [3:0] REQ_RESET       = 4'd7;
   localparam logic [3:0] REQ_READ_BACK   = 4'd8;
   localparam logic [3:0] REQ_LOAD_TX     = 4'd9;

   // Phase codes
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_TX_ADDR = 3'd1;
   localparam logic [2:0] PH_TX_DATA = 3'd2;
   localparam logic [2:0] PH_TX_DONE = 3'd3;
   localparam logic [2:0] PH_RX_ADDR = 3'd4;
   localparam logic [2:0] PH_RX_DATA = 3'd5;
   localparam logic [2:0] PH_RX_DONE = 3'd6;
   localparam logic [2:0] PH_ERROR   = 3'd7;

   // Result codes
   localparam logic [1:0] RES_OK   = 2'd0;
   localparam logic [1:0] RES_BUS  = 2'd1;
   localparam logic [1:0] RES_ARB  = 2'd2;
   localparam logic [1:0] RES_NACK = 2'd3;

   // Start request status codes
   localparam logic [1:0] STAT_ACCEPTED = 2'd0;
   localparam logic [1:0] STAT_INVALID  = 2'd1;
   localparam logic [1:0] STAT_BUSY     = 2'd2;

   // Acknowledge control codes
   localparam logic [1:0] ACK_KEEP = 2'd0;
   localparam logic [1:0] ACK_ACK  = 2'd1;
   localparam logic [1:0] ACK_NACK = 2'd2;

   // Input item
   typedef struct packed {
      logic [3:0] req_type;
      logic [6:0] target_address;
      logic [7:0] transfer_length;
      logic       stop_after_write;
      logic [7:0] byte_value;
      logic [4:0] buffer_index;
      logic       byte_finished;
      logic       bus_error_flag;
      logic       arb_lost_flag;
      logic       ack_fail_flag;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic [1:0] request_status;
      logic [1:0] result_code;
      logic       drive_start;
      logic       drive_stop;
      logic       send_valid;
      logic [7:0] send_byte;
      logic [1:0] ack_control;
      logic [2:0] phase;
      logic       is_idle;
      logic [5:0] received_count;
      logic [7:0] read_data;
   } rsp_item_type;

   // Buffer write commands from the sequencer to the buffer memories
   typedef struct packed {
      logic              tx_we;
      logic [BUF_AW-1:0] tx_waddr;
      logic [7:0]        tx_wdata;
      logic              rx_we;
      logic [BUF_AW-1:0] rx_waddr;
      logic [7:0]        rx_wdata;
   } buf_wr_type;

endpackage

FILE: sv/i2cms_buf.sv
// Transmit and receive byte stores, registered read.
module i2cms_buf (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [i2cms_pkg::BUF_AW-1:0] tx_raddr,
   input  logic [i2cms_pkg::BUF_AW-1:0] rx_raddr,
   input  i2cms_pkg::buf_wr_type       wr,
   output logic [7:0]                  tx_rdata,
   output logic [7:0]                  rx_rdata
);

   logic [7:0] tx_mem [i2cms_pkg::BUF_DEPTH];
   logic [7:0] rx_mem [i2cms_pkg::BUF_DEPTH];
   logic [7:0] tx_rdata_ff;
   logic [7:0] rx_rdata_ff;

   // Writes
   always_ff @(posedge clock) begin
      if (wr.tx_we) begin
         tx_mem[wr.tx_waddr] <= wr.tx_wdata;
      end
      if (wr.rx_we) begin
         rx_mem[wr.rx_waddr] <= wr.rx_wdata;
      end
   end

   // Registered reads, captured when an item is taken in
   always_ff @(posedge clock) begin
      if (rd_en) begin
         tx_rdata_ff <= tx_mem[tx_raddr];
         rx_rdata_ff <= rx_mem[rx_raddr];
      end
   end

   assign tx_rdata = tx_rdata_ff;
   assign rx_rdata = rx_rdata_ff;

endmodule

FILE: sv/i2cms_seq.sv
// Transfer sequencer state and per-item update and result logic.
module i2cms_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         exec,
   input  i2cms_pkg::req_item_type      item,
   input  logic [7:0]                   tx_rdata,
   input  logic [7:0]                   rx_rdata,
   output logic [i2cms_pkg::CNT_W-1:0]  write_pos,
   output i2cms_pkg::rsp_item_type      rsp,
   output i2cms_pkg::buf_wr_type        wr
);

   logic [2:0]                  phase_ff, phase_in;
   logic [1:0]                  result_ff, result_in;
   logic [6:0]                  addr_ff, addr_in;
   logic [i2cms_pkg::CNT_W-1:0] wlen_ff, wlen_in;
   logic [i2cms_pkg::CNT_W-1:0] wpos_ff, wpos_in;
   logic [i2cms_pkg::CNT_W-1:0] rexp_ff, rexp_in;
   logic [i2cms_pkg::CNT_W-1:0] rpos_ff, rpos_in;
   logic [i2cms_pkg::CNT_W-1:0] rcnt_ff, rcnt_in;
   logic                        stop_ff, stop_in;
   i2cms_pkg::buf_wr_type       wr_cmd;

   function automatic logic idle_like(input logic [2:0] ph);
      return ph == i2cms_pkg::PH_IDLE || ph == i2cms_pkg::PH_TX_DONE ||
             ph == i2cms_pkg::PH_RX_DONE || ph == i2cms_pkg::PH_ERROR;
   endfunction

   // Next state and result for the item in execution
   always_comb begin
      logic [1:0]                  status;
      logic [i2cms_pkg::CNT_W-1:0] rp_next;
      logic [i2cms_pkg::CNT_W-1:0] idx_ext;

      phase_in  = phase_ff;
      result_in = result_ff;
      addr_in   = addr_ff;
      wlen_in   = wlen_ff;
      wpos_in   = wpos_ff;
      rexp_in   = rexp_ff;
      rpos_in   = rpos_ff;
      rcnt_in   = rcnt_ff;
      stop_in   = stop_ff;
      rsp       = '0;
      wr_cmd    = '0;
      rp_next   = rpos_ff + 1'b1;
      idx_ext   = {1'b0, item.buffer_index};

      // start request check: bad length first, then busy
      if (item.transfer_length == 8'd0 ||
          item.transfer_length > 8'(i2cms_pkg::BUF_DEPTH)) begin
         status = i2cms_pkg::STAT_INVALID;
      end else if (!idle_like(phase_ff)) begin
         status = i2cms_pkg::STAT_BUSY;
      end else begin
         status = i2cms_pkg::STAT_ACCEPTED;
      end

      unique case (item.req_type)
         i2cms_pkg::REQ_START_WRITE: begin
            rsp.request_status = status;
            if (status == i2cms_pkg::STAT_ACCEPTED) begin
               addr_in         = item.target_address;
               wlen_in         = item.transfer_length[i2cms_pkg::CNT_W-1:0];
               stop_in         = item.stop_after_write;
               wpos_in         = '0;
               result_in       = i2cms_pkg::RES_OK;
               phase_in        = i2cms_pkg::PH_TX_ADDR;
               rsp.drive_start = 1'b1;
            end
         end
         i2cms_pkg::REQ_START_READ: begin
            rsp.request_status = status;
            if (status == i2cms_pkg::STAT_ACCEPTED) begin
               addr_in         = item.target_address;
               rexp_in         = item.transfer_length[i2cms_pkg::CNT_W-1:0];
               rpos_in         = '0;
               rcnt_in         = '0;
               result_in       = i2cms_pkg::RES_OK;
               phase_in        = i2cms_pkg::PH_RX_ADDR;
               rsp.drive_start = 1'b1;
            end
         end
         i2cms_pkg::REQ_START_SENT: begin
            // address byte with read/write bit
            if (phase_ff == i2cms_pkg::PH_TX_ADDR) begin
               rsp.send_valid = 1'b1;
               rsp.send_byte  = {addr_ff, 1'b0};
            end else if (phase_ff == i2cms_pkg::PH_RX_ADDR) begin
               rsp.send_valid = 1'b1;
               rsp.send_byte  = {addr_ff, 1'b1};
            end
         end
         i2cms_pkg::REQ_ADDR_SENT: begin
            if (phase_ff == i2cms_pkg::PH_TX_ADDR) begin
               phase_in = i2cms_pkg::PH_TX_DATA;
            end else if (phase_ff == i2cms_pkg::PH_RX_ADDR) begin
               phase_in = i2cms_pkg::PH_RX_DATA;
               // single-byte read: NACK and stop right away
               if (rexp_ff == i2cms_pkg::CNT_W'(1)) begin
                  rsp.ack_control = i2cms_pkg::ACK_NACK;
                  rsp.drive_stop  = 1'b1;
               end else begin
                  rsp.ack_control = i2cms_pkg::ACK_ACK;
               end
            end
         end
         i2cms_pkg::REQ_TX_EMPTY: begin
            if (phase_ff == i2cms_pkg::PH_TX_DATA) begin
               if (wpos_ff < wlen_ff) begin
                  rsp.send_valid = 1'b1;
                  rsp.send_byte  = tx_rdata;
                  wpos_in        = wpos_ff + 1'b1;
               end else if (item.byte_finished) begin
                  rsp.drive_stop = stop_ff;
                  phase_in       = i2cms_pkg::PH_TX_DONE;
                  result_in      = i2cms_pkg::RES_OK;
               end
            end
         end
         i2cms_pkg::REQ_BYTE_RCVD: begin
            if (phase_ff == i2cms_pkg::PH_RX_DATA) begin
               wr_cmd.rx_we    = !rpos_ff[i2cms_pkg::CNT_W-1];
               wr_cmd.rx_waddr = rpos_ff[i2cms_pkg::BUF_AW-1:0];
               wr_cmd.rx_wdata = item.byte_value;
               rpos_in         = rp_next;
               // NACK ahead of the last byte
               if (rexp_ff != '0 && rp_next == rexp_ff - 1'b1) begin
                  rsp.ack_control = i2cms_pkg::ACK_NACK;
                  rsp.drive_stop  = 1'b1;
               end
               if (rp_next >= rexp_ff) begin
                  rcnt_in   = rp_next;
                  phase_in  = i2cms_pkg::PH_RX_DONE;
                  result_in = i2cms_pkg::RES_OK;
               end
            end
         end
         i2cms_pkg::REQ_ERROR: begin
            priority if (item.ack_fail_flag) begin
               result_in      = i2cms_pkg::RES_NACK;
               rsp.drive_stop = 1'b1;
            end else if (item.arb_lost_flag) begin
               result_in = i2cms_pkg::RES_ARB;
            end else if (item.bus_error_flag) begin
               result_in = i2cms_pkg::RES_BUS;
            end else begin
               result_in = result_ff;
            end
            phase_in = i2cms_pkg::PH_ERROR;
         end
         i2cms_pkg::REQ_RESET: begin
            phase_in  = i2cms_pkg::PH_IDLE;
            result_in = i2cms_pkg::RES_OK;
            wpos_in   = '0;
            wlen_in   = '0;
            rpos_in   = '0;
            rcnt_in   = '0;
         end
         i2cms_pkg::REQ_READ_BACK: begin
            if (idx_ext < rcnt_ff) begin
               rsp.read_data = rx_rdata;
            end
         end
         i2cms_pkg::REQ_LOAD_TX: begin
            wr_cmd.tx_we    = 1'b1;
            wr_cmd.tx_waddr = item.buffer_index;
            wr_cmd.tx_wdata = item.byte_value;
         end
         default: begin
         end
      endcase

      rsp.result_code    = result_in;
      rsp.phase          = phase_in;
      rsp.is_idle        = idle_like(phase_in);
      rsp.received_count = rcnt_in;
   end

   // Memory writes only for the item that executes
   always_comb begin
      wr       = wr_cmd;
      wr.tx_we = wr_cmd.tx_we && exec;
      wr.rx_we = wr_cmd.rx_we && exec;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= i2cms_pkg::PH_IDLE;
         result_ff <= i2cms_pkg::RES_OK;
         addr_ff   <= '0;
         wlen_ff   <= '0;
         wpos_ff   <= '0;
         rexp_ff   <= '0;
         rpos_ff   <= '0;
         rcnt_ff   <= '0;
         stop_ff   <= 1'b0;
      end else if (exec) begin
         phase_ff  <= phase_in;
         result_ff <= result_in;
         addr_ff   <= addr_in;
         wlen_ff   <= wlen_in;
         wpos_ff   <= wpos_in;
         rexp_ff   <= rexp_in;
         rpos_ff   <= rpos_in;
         rcnt_ff   <= rcnt_in;
         stop_ff   <= stop_in;
      end
   end

   assign write_pos = wpos_ff;

endmodule

FILE: sv/i2c_master_transfer_sequencer.sv
// A taken request waits in the pending register, then executes into the output
// register; execution waits while an earlier result is still stalled there.
// Each item has a buffer read step, then an execute step; the next request is
// held off while an item sits between the two.
// A finished result waits in an output register while the next request is taken.
// Reset (synchronous) clears phase, result, counters and handshakes;
// the byte stores are not cleared.
module i2c_master_transfer_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  i2cms_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output i2cms_pkg::rsp_item_type rsp_data
);

   logic                         pend_ff;
   i2cms_pkg::req_item_type      item_ff;
   logic                         rsp_valid_ff;
   i2cms_pkg::rsp_item_type      rsp_ff;
   logic                         accept;
   logic                         exec;
   logic [i2cms_pkg::CNT_W-1:0]  write_pos;
   logic [7:0]                   tx_rdata;
   logic [7:0]                   rx_rdata;
   i2cms_pkg::rsp_item_type      rsp_next;
   i2cms_pkg::buf_wr_type        wr;

   // Handshake: one item in flight, output register frees the result side
   assign accept    = req_valid && !pend_ff;
   assign exec      = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Pending item and output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pend_ff <= 1'b1;
         end else if (exec) begin
            pend_ff <= 1'b0;
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (exec) begin
         rsp_ff <= rsp_next;
      end
   end

   // Byte stores, read when the request transfer is taken
   i2cms_buf u_buf (
      .clock    (clock),
      .rd_en    (accept),
      .tx_raddr (write_pos[i2cms_pkg::BUF_AW-1:0]),
      .rx_raddr (req_data.buffer_index),
      .wr       (wr),
      .tx_rdata (tx_rdata),
      .rx_rdata (rx_rdata)
   );

   // Sequencer state and execution
   i2cms_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .exec      (exec),
      .item      (item_ff),
      .tx_rdata  (tx_rdata),
      .rx_rdata  (rx_rdata),
      .write_pos (write_pos),
      .rsp       (rsp_next),
      .wr        (wr)
   );

endmodule

FILE: tb/tb_i2c_master_transfer_sequencer.sv
// Self-checking testbench for the I2C master transfer sequencer.
module tb_i2c_master_transfer_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   // Highest request code; codes above REQ_LOAD_TX are unused
   localparam logic [3:0] REQ_CODE_MAX = 4'd15;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   i2cms_pkg::req_item_type req_data;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   i2cms_pkg::rsp_item_type rsp_data;

   i2c_master_transfer_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Sequencer state as the testbench tracks it
   logic [2:0]   seq_phase  = i2cms_pkg::PH_IDLE;
   logic [1:0]   seq_result = i2cms_pkg::RES_OK;
   logic [6:0]   seq_addr   = '0;
   logic [5:0]   seq_wr_len = '0;
   logic [5:0]   seq_wr_pos = '0;
   logic [5:0]   seq_rd_len = '0;
   logic [5:0]   seq_rd_pos = '0;
   logic [5:0]   seq_rd_cnt = '0;
   logic         seq_stop   = 1'b0;
   logic [7:0]   tx_bytes [i2cms_pkg::BUF_DEPTH];
   logic [7:0]   rx_bytes [i2cms_pkg::BUF_DEPTH];
   bit           tx_loaded [i2cms_pkg::BUF_DEPTH];

   i2cms_pkg::rsp_item_type pending_rsp_q [$];
   int           error_count  = 0;
   int           items_sent   = 0;
   int           snd_idle_pct = 0;
   int           rcv_idle_pct = 0;

   function automatic bit phase_at_rest(input logic [2:0] ph);
      return ph == i2cms_pkg::PH_IDLE || ph == i2cms_pkg::PH_TX_DONE ||
             ph == i2cms_pkg::PH_RX_DONE || ph == i2cms_pkg::PH_ERROR;
   endfunction

   // Length check first, then busy check
   function automatic logic [1:0] start_status(input logic [7:0] len);
      if (len == 0 || len > i2cms_pkg::BUF_DEPTH) return i2cms_pkg::STAT_INVALID;
      if (!phase_at_rest(seq_phase)) return i2cms_pkg::STAT_BUSY;
      return i2cms_pkg::STAT_ACCEPTED;
   endfunction

   // Advance the tracked state by one request and return the expected result
   function automatic i2cms_pkg::rsp_item_type sequence_step(
      input i2cms_pkg::req_item_type r);
      i2cms_pkg::rsp_item_type o;
      o = '0;
      case (r.req_type)
         i2cms_pkg::REQ_START_WRITE: begin
            o.request_status = start_status(r.transfer_length);
            if (o.request_status == i2cms_pkg::STAT_ACCEPTED) begin
               seq_addr      = r.target_address;
               seq_wr_len    = r.transfer_length[5:0];
               seq_stop      = r.stop_after_write;
               seq_wr_pos    = '0;
               seq_result    = i2cms_pkg::RES_OK;
               seq_phase     = i2cms_pkg::PH_TX_ADDR;
               o.drive_start = 1'b1;
            end
         end
         i2cms_pkg::REQ_START_READ: begin
            o.request_status = start_status(r.transfer_length);
            if (o.request_status == i2cms_pkg::STAT_ACCEPTED) begin
               seq_addr      = r.target_address;
               seq_rd_len    = r.transfer_length[5:0];
               seq_rd_pos    = '0;
               seq_rd_cnt    = '0;
               seq_result    = i2cms_pkg::RES_OK;
               seq_phase     = i2cms_pkg::PH_RX_ADDR;
               o.drive_start = 1'b1;
            end
         end
         i2cms_pkg::REQ_START_SENT: begin
            if (seq_phase == i2cms_pkg::PH_TX_ADDR) begin
               o.send_valid = 1'b1;
               o.send_byte  = {seq_addr, 1'b0};
            end else if (seq_phase == i2cms_pkg::PH_RX_ADDR) begin
               o.send_valid = 1'b1;
               o.send_byte  = {seq_addr, 1'b1};
            end
         end
         i2cms_pkg::REQ_ADDR_SENT: begin
            if (seq_phase == i2cms_pkg::PH_TX_ADDR) begin
               seq_phase = i2cms_pkg::PH_TX_DATA;
            end else if (seq_phase == i2cms_pkg::PH_RX_ADDR) begin
               seq_phase = i2cms_pkg::PH_RX_DATA;
               // single-byte read: NACK and stop right away
               if (seq_rd_len == 6'd1) begin
                  o.ack_control = i2cms_pkg::ACK_NACK;
                  o.drive_stop  = 1'b1;
               end else begin
                  o.ack_control = i2cms_pkg::ACK_ACK;
               end
            end
         end
         i2cms_pkg::REQ_TX_EMPTY: begin
            if (seq_phase == i2cms_pkg::PH_TX_DATA) begin
               if (seq_wr_pos < seq_wr_len) begin
                  o.send_valid = 1'b1;
                  o.send_byte  = tx_bytes[seq_wr_pos[4:0]];
                  seq_wr_pos++;
               end else if (r.byte_finished) begin
                  o.drive_stop = seq_stop;
                  seq_phase    = i2cms_pkg::PH_TX_DONE;
                  seq_result   = i2cms_pkg::RES_OK;
               end
            end
         end
         i2cms_pkg::REQ_BYTE_RCVD: begin
            if (seq_phase == i2cms_pkg::PH_RX_DATA) begin
               if (seq_rd_pos < i2cms_pkg::BUF_DEPTH) begin
                  rx_bytes[seq_rd_pos[4:0]] = r.byte_value;
               end
               seq_rd_pos++;
               // NACK ahead of the last byte
               if (seq_rd_len >= 6'd1 && seq_rd_pos == seq_rd_len - 6'd1) begin
                  o.ack_control = i2cms_pkg::ACK_NACK;
                  o.drive_stop  = 1'b1;
               end
               if (seq_rd_pos >= seq_rd_len) begin
                  seq_rd_cnt = seq_rd_pos;
                  seq_phase  = i2cms_pkg::PH_RX_DONE;
                  seq_result = i2cms_pkg::RES_OK;
               end
            end
         end
         i2cms_pkg::REQ_ERROR: begin
            // NACK over arbitration lost over bus error
            if (r.ack_fail_flag) begin
               seq_result   = i2cms_pkg::RES_NACK;
               o.drive_stop = 1'b1;
            end else if (r.arb_lost_flag) begin
               seq_result = i2cms_pkg::RES_ARB;
            end else if (r.bus_error_flag) begin
               seq_result = i2cms_pkg::RES_BUS;
            end
            seq_phase = i2cms_pkg::PH_ERROR;
         end
         i2cms_pkg::REQ_RESET: begin
            seq_phase  = i2cms_pkg::PH_IDLE;
            seq_result = i2cms_pkg::RES_OK;
            seq_wr_pos = '0;
            seq_wr_len = '0;
            seq_rd_pos = '0;
            seq_rd_cnt = '0;
         end
         i2cms_pkg::REQ_READ_BACK: begin
            if (r.buffer_index < seq_rd_cnt) o.read_data = rx_bytes[r.buffer_index];
         end
         i2cms_pkg::REQ_LOAD_TX: begin
            tx_bytes[r.buffer_index]  = r.byte_value;
            tx_loaded[r.buffer_index] = 1'b1;
         end
         default: ;
      endcase
      o.result_code    = seq_result;
      o.phase          = seq_phase;
      o.is_idle        = phase_at_rest(seq_phase);
      o.received_count = seq_rd_cnt;
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp,
                                       input logic [7:0] got);
      if (got !== exp) begin
         $error("%s: expected %0h, got %0h", name, exp, got);
         error_count++;
      end
   endfunction

   // Result checker and receiver stall
   always @(posedge clock) begin : rsp_check
      i2cms_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            $error("result %h with none expected", rsp_data);
            error_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            check_field("request_status", want.request_status, rsp_data.request_status);
            check_field("result_code", want.result_code, rsp_data.result_code);
            check_field("drive_start", want.drive_start, rsp_data.drive_start);
            check_field("drive_stop", want.drive_stop, rsp_data.drive_stop);
            check_field("send_valid", want.send_valid, rsp_data.send_valid);
            check_field("send_byte", want.send_byte, rsp_data.send_byte);
            check_field("ack_control", want.ack_control, rsp_data.ack_control);
            check_field("phase", want.phase, rsp_data.phase);
            check_field("is_idle", want.is_idle, rsp_data.is_idle);
            check_field("received_count", want.received_count, rsp_data.received_count);
            check_field("read_data", want.read_data, rsp_data.read_data);
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
   end

   // One request transfer; expectation recorded at acceptance
   task automatic send_req(input i2cms_pkg::req_item_type item);
      // never let the block send a transmit byte that was never loaded
      if (item.req_type == i2cms_pkg::REQ_TX_EMPTY && seq_phase == i2cms_pkg::PH_TX_DATA &&
          seq_wr_pos < seq_wr_len && !tx_loaded[seq_wr_pos[4:0]]) begin
         item.req_type     = i2cms_pkg::REQ_LOAD_TX;
         item.buffer_index = seq_wr_pos[4:0];
      end
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp_q.push_back(sequence_step(item));
      if (item.req_type <= i2cms_pkg::REQ_LOAD_TX) items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   function automatic i2cms_pkg::req_item_type random_req();
      i2cms_pkg::req_item_type r;
      r.req_type         = 4'($urandom_range(0, REQ_CODE_MAX));
      r.target_address   = 7'($urandom);
      r.transfer_length  = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 40));
      r.stop_after_write = 1'($urandom);
      r.byte_value       = 8'($urandom);
      r.buffer_index     = 5'($urandom);
      r.byte_finished    = 1'($urandom);
      r.bus_error_flag   = 1'($urandom);
      r.arb_lost_flag    = 1'($urandom);
      r.ack_fail_flag    = 1'($urandom);
      return r;
   endfunction

   function automatic i2cms_pkg::req_item_type make_req(input logic [3:0] kind);
      i2cms_pkg::req_item_type r;
      r          = random_req();
      r.req_type = kind;
      return r;
   endfunction

   // Mostly short transfers, now and then up to the full buffer
   function automatic int pick_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 80) return $urandom_range(1, 4);
      if (p < 95) return $urandom_range(5, 16);
      return $urandom_range(17, i2cms_pkg::BUF_DEPTH);
   endfunction

   // Sequence step with an occasional stray request in front of it
   task automatic send_step(input i2cms_pkg::req_item_type item);
      if ($urandom_range(0, 99) < 3) send_req(random_req());
      send_req(item);
   endtask

   task automatic run_write_sequence();
      i2cms_pkg::req_item_type r;
      int len;
      len = pick_length();
      for (int i = 0; i < len; i++) begin
         if (!tx_loaded[i] || $urandom_range(0, 3) == 0) begin
            r              = make_req(i2cms_pkg::REQ_LOAD_TX);
            r.buffer_index = 5'(i);
            send_step(r);
         end
      end
      r                 = make_req(i2cms_pkg::REQ_START_WRITE);
      r.transfer_length = 8'(len);
      send_step(r);
      send_step(make_req(i2cms_pkg::REQ_START_SENT));
      send_step(make_req(i2cms_pkg::REQ_ADDR_SENT));
      for (int i = 0; i < len; i++) send_step(make_req(i2cms_pkg::REQ_TX_EMPTY));
      if ($urandom_range(0, 3) == 0) begin
         r               = make_req(i2cms_pkg::REQ_TX_EMPTY);
         r.byte_finished = 1'b0;
         send_step(r);
      end
      r               = make_req(i2cms_pkg::REQ_TX_EMPTY);
      r.byte_finished = 1'b1;
      send_step(r);
   endtask

   task automatic run_read_sequence();
      i2cms_pkg::req_item_type r;
      int len;
      len               = pick_length();
      r                 = make_req(i2cms_pkg::REQ_START_READ);
      r.transfer_length = 8'(len);
      send_step(r);
      send_step(make_req(i2cms_pkg::REQ_START_SENT));
      send_step(make_req(i2cms_pkg::REQ_ADDR_SENT));
      for (int i = 0; i < len; i++) send_step(make_req(i2cms_pkg::REQ_BYTE_RCVD));
      repeat ($urandom_range(1, 3)) begin
         r              = make_req(i2cms_pkg::REQ_READ_BACK);
         r.buffer_index = ($urandom_range(0, 7) == 0) ? 5'd31 : 5'($urandom_range(0, len));
         send_step(r);
      end
   endtask

   // Start requests with lengths out of range
   task automatic test_bad_length();
      i2cms_pkg::req_item_type r;
      r                 = make_req(i2cms_pkg::REQ_START_WRITE);
      r.transfer_length = 8'd0;
      send_req(r);
      r                 = make_req(i2cms_pkg::REQ_START_READ);
      r.transfer_length = 8'd255;
      r.target_address  = 7'd127;
      send_req(r);
   endtask

   // Two-byte write with stop, busy start, tx empty at end without finish
   task automatic test_write_transfer();
      i2cms_pkg::req_item_type r;
      r              = make_req(i2cms_pkg::REQ_LOAD_TX);
      r.buffer_index = 5'd0;
      r.byte_value   = 8'hFF;
      send_req(r);
      r              = make_req(i2cms_pkg::REQ_LOAD_TX);
      r.buffer_index = 5'd1;
      r.byte_value   = 8'h00;
      send_req(r);
      r                  = make_req(i2cms_pkg::REQ_START_WRITE);
      r.target_address   = 7'd127;
      r.transfer_length  = 8'd2;
      r.stop_after_write = 1'b1;
      send_req(r);
      r                 = make_req(i2cms_pkg::REQ_START_READ);
      r.transfer_length = 8'd1;
      send_req(r);
      send_req(make_req(i2cms_pkg::REQ_START_SENT));
      send_req(make_req(i2cms_pkg::REQ_ADDR_SENT));
      repeat (2) send_req(make_req(i2cms_pkg::REQ_TX_EMPTY));
      r               = make_req(i2cms_pkg::REQ_TX_EMPTY);
      r.byte_finished = 1'b0;
      send_req(r);
      r.byte_finished = 1'b1;
      send_req(r);
   endtask

   // Single-byte read, then read back inside and outside the count
   task automatic test_read_transfer();
      i2cms_pkg::req_item_type r;
      r                 = make_req(i2cms_pkg::REQ_START_READ);
      r.target_address  = 7'd0;
      r.transfer_length = 8'd1;
      send_req(r);
      send_req(make_req(i2cms_pkg::REQ_START_SENT));
      send_req(make_req(i2cms_pkg::REQ_ADDR_SENT));
      r            = make_req(i2cms_pkg::REQ_BYTE_RCVD);
      r.byte_value = 8'hFF;
      send_req(r);
      r              = make_req(i2cms_pkg::REQ_READ_BACK);
      r.buffer_index = 5'd0;
      send_req(r);
      r.buffer_index = 5'd31;
      send_req(r);
   endtask

   // Flag priority on error events, including no flag at all
   task automatic test_error_priority();
      i2cms_pkg::req_item_type r;
      r                = make_req(i2cms_pkg::REQ_ERROR);
      r.ack_fail_flag  = 1'b1;
      r.arb_lost_flag  = 1'b1;
      r.bus_error_flag = 1'b1;
      send_req(r);
      r.ack_fail_flag  = 1'b0;
      send_req(r);
      r.arb_lost_flag  = 1'b0;
      send_req(r);
      r.bus_error_flag = 1'b0;
      send_req(r);
   endtask

   // Reset request, unused code, event in the wrong phase
   task automatic test_reset_and_stray();
      send_req(make_req(i2cms_pkg::REQ_RESET));
      send_req(make_req(REQ_CODE_MAX));
      send_req(make_req(i2cms_pkg::REQ_TX_EMPTY));
   endtask

   task automatic test_random_traffic(input int n_items);
      int stop_at;
      int pick;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            run_write_sequence();
         end else if (pick < 80) begin
            run_read_sequence();
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 4))
               send_req(make_req($urandom_range(0, 1) ? i2cms_pkg::REQ_LOAD_TX :
                                                        i2cms_pkg::REQ_READ_BACK));
         end else begin
            repeat ($urandom_range(1, 4)) send_req(random_req());
         end
      end
      wait_drained();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      snd_idle_pct = 7;
      rcv_idle_pct = 51;
      test_bad_length();
      test_write_transfer();
      test_read_transfer();
      test_error_priority();
      test_reset_and_stray();
      wait_drained();
      test_random_traffic(700);

      snd_idle_pct = 51;
      rcv_idle_pct = 7;
      test_random_traffic(700);

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random_traffic(600);

      // let the clock run on so no stray result goes unseen
      repeat (4) @(posedge clock);
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
